// File: hdl/ght_pkg.sv
// Package: widths, codes, payload and control types of the handle table.
package ght_pkg;

    localparam int NUM_SLOTS = 64;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int FUNC_W    = 3;
    localparam int IDX_W     = 8;
    localparam int GEN_W     = 32;
    localparam int TYPE_W    = 4;
    localparam int OWN_W     = 16;
    localparam int PAY_W     = 64;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = TYPE_W;

    typedef enum logic [FUNC_W-1:0] {
        FN_RESERVE  = 3'd0,
        FN_RELEASE  = 3'd1,
        FN_VALIDATE = 3'd2,
        FN_TRANSFER = 3'd3,
        FN_GET      = 3'd4,
        FN_SET      = 3'd5
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANY_TYPE  = 1'b0,
        CFG_ROOT_TYPE = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [IDX_W-1:0]  slot_index;
        logic [GEN_W-1:0]  generation;
        logic [TYPE_W-1:0] res_type;
        logic [OWN_W-1:0]  requester;
        logic [PAY_W-1:0]  payload_in;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  reserved_index;
        logic [GEN_W-1:0]  generation_out;
        logic              valid_res;
        logic [PAY_W-1:0]  payload_out;
    } t_rsp;

    typedef struct packed {
        logic [GEN_W-1:0]  gen;
        logic [TYPE_W-1:0] typ;
        logic [OWN_W-1:0]  own;
        logic [PAY_W-1:0]  pay;
    } t_entry;

    typedef struct packed {
        logic in_ready;
        logic capture;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_hold;
    } t_stat;

endpackage

// File: hdl/ght_req_if.sv
// Interface: request channel carrying one table operation.
interface ght_req_if;
    import ght_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/ght_rsp_if.sv
// Interface: response channel carrying one operation result.
interface ght_rsp_if;
    import ght_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/ght_ctrl.sv
// Controller: accept and commit sequencing of the handle table.
module ght_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  ght_pkg::t_stat i_stat,
    output ght_pkg::t_cmd  o_cmd
);
    import ght_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_stat.out_hold) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.capture  = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.commit = !i_stat.out_hold;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// File: hdl/ght_dp.sv
// Datapath: slot flags, slot memory, free-slot encoder and result register.
module ght_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ght_pkg::t_cmd     i_cmd,
    output ght_pkg::t_stat    o_stat,
    input  ght_pkg::t_req     i_req_data,
    input  logic              i_rsp_ready,
    output logic              o_rsp_valid,
    output ght_pkg::t_rsp     o_rsp_data,
    input  logic              i_cfg_we,
    input  logic [ght_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ght_pkg::CFG_W-1:0]     i_cfg_data
);
    import ght_pkg::*;

    logic [TYPE_W-1:0]    r_any_type;
    logic [TYPE_W-1:0]    r_root_type;

    logic [NUM_SLOTS-1:0] r_in_use;
    logic [NUM_SLOTS-1:0] r_pay_nz;
    logic [NUM_SLOTS-1:0] r_wr_vld;
    t_entry               r_mem [NUM_SLOTS];

    logic [FUNC_W-1:0]    r_func;
    logic [GEN_W-1:0]     r_gen;
    logic [TYPE_W-1:0]    r_type;
    logic [OWN_W-1:0]     r_req;
    logic [PAY_W-1:0]     r_pay;
    logic                 r_range;
    logic                 r_found;
    logic [SLOT_W-1:0]    r_addr;
    t_entry               r_rd;
    logic                 r_rd_vld;

    logic                 r_out_valid;
    t_rsp                 r_out;

    logic [NUM_SLOTS-1:0] free_vec;
    logic [SLOT_W-1:0]    free_idx;
    logic                 free_found;
    logic [SLOT_W-1:0]    rd_addr;
    logic                 in_range;

    t_entry               ent;
    logic                 slot_used;
    logic                 wr_en;
    t_entry               wr_ent;
    logic                 use_we;
    logic                 use_val;
    logic                 nz_we;
    logic                 nz_val;
    t_rsp                 rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any_type  <= TYPE_W'(15);
            r_root_type <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ANY_TYPE:  r_any_type  <= i_cfg_data;
                CFG_ROOT_TYPE: r_root_type <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign free_vec = ~r_in_use & ~r_pay_nz;
    assign in_range = i_req_data.slot_index < IDX_W'(NUM_SLOTS);

    always_comb begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (free_vec[i]) begin
                free_idx   = SLOT_W'(i);
                free_found = 1'b1;
            end
        end
    end

    assign rd_addr = (t_func'(i_req_data.func) == FN_RESERVE) ? free_idx
                   : i_req_data.slot_index[SLOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func   <= i_req_data.func;
            r_gen    <= i_req_data.generation;
            r_type   <= i_req_data.res_type;
            r_req    <= i_req_data.requester;
            r_pay    <= i_req_data.payload_in;
            r_range  <= !in_range;
            r_found  <= free_found;
            r_addr   <= rd_addr;
            r_rd     <= r_mem[rd_addr];
        end
        if (wr_en) begin
            r_mem[r_addr] <= wr_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (i_cmd.capture) begin
            r_rd_vld <= r_wr_vld[rd_addr];
        end
    end

    assign ent       = r_rd_vld ? r_rd : '0;
    assign slot_used = r_in_use[r_addr];

    always_comb begin
        wr_en   = 1'b0;
        wr_ent  = ent;
        use_we  = 1'b0;
        use_val = 1'b0;
        nz_we   = 1'b0;
        nz_val  = 1'b0;
        rsp     = '0;
        if (t_func'(r_func) == FN_RESERVE) begin
            if (r_found) begin
                wr_en              = 1'b1;
                wr_ent.gen         = ent.gen + GEN_W'(1);
                wr_ent.typ         = r_type;
                wr_ent.own         = r_req;
                use_we             = 1'b1;
                use_val            = 1'b1;
                rsp.reserved_index = IDX_W'(r_addr);
                rsp.generation_out = wr_ent.gen;
            end else begin
                rsp.status = ST_FULL;
            end
        end else if (r_func > FUNC_W'(FN_SET)) begin
            rsp.status = ST_DONE;
        end else if (r_range) begin
            rsp.status = ST_RANGE;
        end else begin
            unique case (t_func'(r_func))
                FN_RELEASE: begin
                    wr_en      = 1'b1;
                    wr_ent.typ = r_root_type;
                    wr_ent.own = '0;
                    wr_ent.pay = '0;
                    use_we     = 1'b1;
                    nz_we      = 1'b1;
                end
                FN_VALIDATE: begin
                    rsp.valid_res = slot_used && (ent.gen == r_gen)
                                 && ((ent.typ == r_type) || (r_type == r_any_type))
                                 && (ent.own == r_req);
                end
                FN_TRANSFER: begin
                    if (slot_used) begin
                        wr_en      = 1'b1;
                        wr_ent.own = r_req;
                    end
                end
                FN_GET: begin
                    if (slot_used) begin
                        rsp.payload_out = ent.pay;
                    end
                end
                FN_SET: begin
                    wr_en      = 1'b1;
                    wr_ent.pay = r_pay;
                    nz_we      = 1'b1;
                    nz_val     = (r_pay != '0);
                end
                default: rsp = '0;
            endcase
        end
        if (!i_cmd.commit) begin
            wr_en  = 1'b0;
            use_we = 1'b0;
            nz_we  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= '0;
            r_pay_nz <= '0;
            r_wr_vld <= '0;
        end else begin
            if (use_we) begin
                r_in_use[r_addr] <= use_val;
            end
            if (nz_we) begin
                r_pay_nz[r_addr] <= nz_val;
            end
            if (wr_en) begin
                r_wr_vld[r_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out <= rsp;
        end
    end

    assign o_stat.out_hold = r_out_valid && !i_rsp_ready;
    assign o_rsp_valid     = r_out_valid;
    assign o_rsp_data      = r_out;

endmodule

// File: hdl/generational_handle_table.sv
// Top level: generational handle table with request, response and config ports.
//
//  channel | direction | handshake       | payload
//  i_req   | in        | valid / ready   | func, slot, generation, type, requester, payload
//  o_rsp   | out       | valid / ready   | status, index, generation, valid flag, payload
//  i_cfg_* | in        | write enable    | any type code, root type code
//
// In a transaction, the accept cycle reads the slot memory and flags, and the
// S_EXEC state computes the result and writes the slot back (one read-modify-write).
// Synchronous reset clears the flags and entry valid bits directly; no clearing pass.
// A stalled result holds in the output register; the next request is accepted
// while it waits, and its write-back waits until the output register frees up.
module generational_handle_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ght_req_if.sink                       i_req,
    ght_rsp_if.source                     o_rsp,
    input  logic                          i_cfg_we,
    input  logic [ght_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ght_pkg::CFG_W-1:0]     i_cfg_data
);
    import ght_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    ght_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ght_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_req_data  (i_req.data),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (o_rsp.valid),
        .o_rsp_data  (o_rsp.data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    assign i_req.ready = cmd.in_ready;

`ifndef NO_ASSERTIONS
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> !(o_rsp.valid && !o_rsp.ready))
        else $error("commit while result register is held");

    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> o_rsp.valid)
        else $error("committed transaction did not reach the output");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (!i_req.ready && !cmd.capture))
        else $error("second request accepted before write-back");
`endif

endmodule
